// ===== src/fpn_pkg.sv =====
// Shared types, register codes and the gradient function for the fractal noise core
`timescale 1ns / 1ps
`default_nettype none
package fpn_pkg;

  localparam logic [16:0] ONE_FX = 17'h10000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REG_PERS = 2'd0;
  localparam logic [1:0] REG_AMP  = 2'd1;
  localparam logic [1:0] REG_FREQ = 2'd2;
  localparam logic [1:0] REG_OCT  = 2'd3;

  typedef struct packed {
    logic [16:0] persistence;
    logic [23:0] start_amplitude;
    logic [23:0] start_frequency;
    logic [3:0]  octave_count;
  } cfg_regs_t;

  function automatic logic signed [18:0] grad(input logic [3:0] h,
                                               input logic signed [17:0] x,
                                               input logic signed [17:0] y,
                                               input logic signed [17:0] z);
    logic signed [18:0] xe;
    logic signed [18:0] ye;
    logic signed [18:0] ze;
    logic signed [18:0] r;
    xe = $signed({x[17], x});
    ye = $signed({y[17], y});
    ze = $signed({z[17], z});
    case (h)
      4'h0: r = xe + ye;
      4'h1: r = -xe + ye;
      4'h2: r = xe - ye;
      4'h3: r = -xe - ye;
      4'h4: r = xe + ze;
      4'h5: r = -xe + ze;
      4'h6: r = xe - ze;
      4'h7: r = -xe - ze;
      4'h8: r = ye + ze;
      4'h9: r = -ye + ze;
      4'hA: r = ye - ze;
      4'hB: r = -ye - ze;
      4'hC: r = ye + xe;
      4'hD: r = -ye + ze;
      4'hE: r = ye - xe;
      default: r = -ye - ze;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/fpn_ram.sv =====
// Generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module fpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/fpn_cfg.sv =====
// APB register bank holding the octave configuration
`timescale 1ns / 1ps
`default_nettype none
module fpn_cfg
  import fpn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_regs_t        cfg
);

  cfg_regs_t  regs_r;
  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];
  assign cfg    = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.persistence     <= 17'd32768;
      regs_r.start_amplitude <= 24'd65536;
      regs_r.start_frequency <= 24'd65536;
      regs_r.octave_count    <= 4'd4;
    end else if (wr) begin
      case (idx)
        REG_PERS: regs_r.persistence     <= pwdata[16:0];
        REG_AMP:  regs_r.start_amplitude <= pwdata[23:0];
        REG_FREQ: regs_r.start_frequency <= pwdata[23:0];
        REG_OCT:  regs_r.octave_count    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERS: prdata = {15'd0, regs_r.persistence};
      REG_AMP:  prdata = {8'd0, regs_r.start_amplitude};
      REG_FREQ: prdata = {8'd0, regs_r.start_frequency};
      REG_OCT:  prdata = {28'd0, regs_r.octave_count};
      default:  prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/fpn_eng.sv =====
// Octave sequencer: permutation table, shared multiplier, lerp and accumulate
`timescale 1ns / 1ps
`default_nettype none
module fpn_eng
  import fpn_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_regs_t   cfg,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        in_op,
  input  wire logic [7:0]  tbl_idx,
  input  wire logic [7:0]  tbl_val,
  input  wire logic [23:0] crd_x,
  input  wire logic [23:0] crd_y,
  input  wire logic [23:0] crd_z,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      noise_value,
  output logic             saturated
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam logic [4:0] LAST_STEP = 5'd26;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_OCT  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [4:0]       step_r, step_nxt;
  logic [OCT_W-1:0] k_r, k_nxt;
  logic [OCT_W-1:0] n_r, n_ev;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      noise_r;
  logic             sat_r;

  logic [23:0] cx_r, cy_r, cz_r;
  logic [47:0] px_r, py_r, pz_r;
  logic [7:0]  icx_r, icy_r, icz_r;
  logic [15:0] fx_r, fy_r, fz_r;
  logic [19:0] e_r;
  logic [16:0] u_r, v_r, w_r;
  logic [7:0]  ha_r, hb_r, haa_r, hab_r, hba_r, hbb_r;
  logic [3:0]  hash_r [8];
  logic signed [20:0] lr_r [7];
  logic [23:0] amp_r;
  logic signed [39:0] tot_r;
  logic signed [51:0] p_r;

  logic        in_acc, is_eval, pers_ok, out_ld;
  logic [7:0]  rd_addr, rd_data;
  logic [63:0] shx, shy, shz;
  logic signed [25:0] ma, mb;
  logic [34:0] six;
  logic [19:0] fif, e_c;
  logic [15:0] f_cur;
  logic [20:0] fr;
  logic [16:0] fd;
  logic signed [17:0] x0, x1, y0, y1, z0, z1;
  logic signed [18:0] g [8];
  logic signed [20:0] dlt, bs, lerp_res;

  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid & in_tready;
  assign is_eval     = (in_op == OP_EVAL);
  assign out_tvalid  = out_valid_r;
  assign noise_value = noise_r;
  assign saturated   = sat_r;
  assign out_ld      = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  fpn_ram #(.WIDTH(8), .DEPTH(256)) u_tbl (
    .clk   (clk),
    .we    (in_acc && (in_op == OP_LOAD)),
    .waddr (tbl_idx),
    .wdata (tbl_val),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    pers_ok = (cfg.persistence != 17'd0) && (cfg.persistence <= ONE_FX);
    if (int'(cfg.octave_count) > MAX_OCTAVES) begin
      n_ev = OCT_W'(MAX_OCTAVES);
    end else begin
      n_ev = OCT_W'(cfg.octave_count);
    end
    if (!pers_ok) begin
      n_ev = '0;
    end
  end

  assign shx = {16'd0, px_r} << k_r;
  assign shy = {16'd0, py_r} << k_r;
  assign shz = {16'd0, pz_r} << k_r;

  // fade helpers: e = 6t^2 + 10 - 15t, clamp of t3*e
  always_comb begin
    case (step_r)
      5'd2:    f_cur = fx_r;
      5'd5:    f_cur = fy_r;
      default: f_cur = fz_r;
    endcase
    six = ({3'd0, p_r[31:0]} << 2) + ({3'd0, p_r[31:0]} << 1);
    fif = ({4'd0, f_cur} << 4) - {4'd0, f_cur};
    e_c = {1'b0, six[34:16]} + 20'd655360 - fif;
    fr  = p_r[36:16];
    fd  = (fr > {4'd0, ONE_FX}) ? ONE_FX : fr[16:0];
  end

  assign x0 = $signed({2'b00, fx_r});
  assign x1 = $signed({2'b11, fx_r});
  assign y0 = $signed({2'b00, fy_r});
  assign y1 = $signed({2'b11, fy_r});
  assign z0 = $signed({2'b00, fz_r});
  assign z1 = $signed({2'b11, fz_r});

  for (genvar gi = 0; gi < 8; gi++) begin : g_grad
    assign g[gi] = grad(hash_r[gi], (gi % 2 != 0) ? x1 : x0,
                        ((gi / 2) % 2 != 0) ? y1 : y0, (gi / 4 != 0) ? z1 : z0);
  end

  always_comb begin
    case (step_r)
      5'd16:   dlt = 21'(g[1]) - 21'(g[0]);
      5'd17:   dlt = 21'(g[3]) - 21'(g[2]);
      5'd18:   dlt = 21'(g[5]) - 21'(g[4]);
      5'd19:   dlt = 21'(g[7]) - 21'(g[6]);
      5'd20:   dlt = lr_r[1] - lr_r[0];
      5'd21:   dlt = lr_r[3] - lr_r[2];
      default: dlt = lr_r[5] - lr_r[4];
    endcase
    case (step_r)
      5'd17:   bs = 21'(g[0]);
      5'd18:   bs = 21'(g[2]);
      5'd19:   bs = 21'(g[4]);
      5'd20:   bs = 21'(g[6]);
      5'd21:   bs = lr_r[0];
      5'd22:   bs = lr_r[2];
      default: bs = lr_r[4];
    endcase
    lerp_res = bs + $signed(p_r[36:16]);
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_r == ST_PREP) begin
      mb = $signed({2'b00, cfg.start_frequency});
      case (step_r)
        5'd0:    ma = $signed({2'b00, cx_r});
        5'd1:    ma = $signed({2'b00, cy_r});
        5'd2:    ma = $signed({2'b00, cz_r});
        default: mb = '0;
      endcase
    end else if (state_r == ST_OCT) begin
      case (step_r)
        5'd1: begin ma = $signed({10'd0, fx_r}); mb = $signed({10'd0, fx_r}); end
        5'd2: begin ma = $signed({10'd0, p_r[31:16]}); mb = $signed({10'd0, fx_r}); end
        5'd3: begin ma = $signed({10'd0, p_r[31:16]}); mb = $signed({6'd0, e_r}); end
        5'd4: begin ma = $signed({10'd0, fy_r}); mb = $signed({10'd0, fy_r}); end
        5'd5: begin ma = $signed({10'd0, p_r[31:16]}); mb = $signed({10'd0, fy_r}); end
        5'd6: begin ma = $signed({10'd0, p_r[31:16]}); mb = $signed({6'd0, e_r}); end
        5'd7: begin ma = $signed({10'd0, fz_r}); mb = $signed({10'd0, fz_r}); end
        5'd8: begin ma = $signed({10'd0, p_r[31:16]}); mb = $signed({10'd0, fz_r}); end
        5'd9: begin ma = $signed({10'd0, p_r[31:16]}); mb = $signed({6'd0, e_r}); end
        5'd16, 5'd17, 5'd18, 5'd19: begin
          ma = $signed({9'd0, u_r});
          mb = 26'(dlt);
        end
        5'd20, 5'd21: begin
          ma = $signed({9'd0, v_r});
          mb = 26'(dlt);
        end
        5'd23: begin ma = $signed({9'd0, w_r}); mb = 26'(dlt); end
        5'd24: begin
          ma = $signed({2'b00, amp_r});
          mb = $signed({9'd0, cfg.persistence});
        end
        5'd25: begin ma = $signed({2'b00, amp_r}); mb = 26'(lr_r[6]); end
        default: ;
      endcase
    end
  end

  // table read address per step
  always_comb begin
    case (step_r)
      5'd1:    rd_addr = icx_r;
      5'd2:    rd_addr = icx_r + 8'd1;
      5'd3:    rd_addr = ha_r;
      5'd4:    rd_addr = ha_r + 8'd1;
      5'd5:    rd_addr = hb_r;
      5'd6:    rd_addr = hb_r + 8'd1;
      5'd7:    rd_addr = haa_r;
      5'd8:    rd_addr = hba_r;
      5'd9:    rd_addr = hab_r;
      5'd10:   rd_addr = hbb_r;
      5'd11:   rd_addr = haa_r + 8'd1;
      5'd12:   rd_addr = hba_r + 8'd1;
      5'd13:   rd_addr = hab_r + 8'd1;
      default: rd_addr = hbb_r + 8'd1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = 5'd0;
        if (in_acc && is_eval) begin
          state_nxt = (n_ev == '0) ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: begin
        if (step_r == 5'd3) begin
          state_nxt = ST_OCT;
          step_nxt  = 5'd0;
          k_nxt     = '0;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ST_OCT: begin
        if (step_r == LAST_STEP) begin
          step_nxt = 5'd0;
          if (OCT_W'(k_r + 1'b1) == n_r) begin
            state_nxt = ST_DONE;
          end else begin
            k_nxt = OCT_W'(k_r + 1'b1);
          end
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ST_DONE: begin
        if (out_ld) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_ld | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 5'd0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    if (in_acc && is_eval) begin
      cx_r  <= crd_x;
      cy_r  <= crd_y;
      cz_r  <= crd_z;
      amp_r <= cfg.start_amplitude;
      tot_r <= '0;
      n_r   <= n_ev;
    end
    if (state_r == ST_PREP) begin
      case (step_r)
        5'd1:    px_r <= p_r[47:0];
        5'd2:    py_r <= p_r[47:0];
        5'd3:    pz_r <= p_r[47:0];
        default: ;
      endcase
    end
    if (state_r == ST_OCT) begin
      case (step_r)
        5'd0: begin
          icx_r <= shx[39:32];
          icy_r <= shy[39:32];
          icz_r <= shz[39:32];
          fx_r  <= shx[31:16];
          fy_r  <= shy[31:16];
          fz_r  <= shz[31:16];
        end
        5'd2: begin
          e_r  <= e_c;
          ha_r <= rd_data + icy_r;
        end
        5'd3: hb_r <= rd_data + icy_r;
        5'd4: begin
          u_r   <= fd;
          haa_r <= rd_data + icz_r;
        end
        5'd5: begin
          e_r   <= e_c;
          hab_r <= rd_data + icz_r;
        end
        5'd6: hba_r <= rd_data + icz_r;
        5'd7: begin
          v_r   <= fd;
          hbb_r <= rd_data + icz_r;
        end
        5'd8: begin
          e_r       <= e_c;
          hash_r[0] <= rd_data[3:0];
        end
        5'd9:  hash_r[1] <= rd_data[3:0];
        5'd10: begin
          w_r       <= fd;
          hash_r[2] <= rd_data[3:0];
        end
        5'd11: hash_r[3] <= rd_data[3:0];
        5'd12: hash_r[4] <= rd_data[3:0];
        5'd13: hash_r[5] <= rd_data[3:0];
        5'd14: hash_r[6] <= rd_data[3:0];
        5'd15: hash_r[7] <= rd_data[3:0];
        5'd17: lr_r[0] <= lerp_res;
        5'd18: lr_r[1] <= lerp_res;
        5'd19: lr_r[2] <= lerp_res;
        5'd20: lr_r[3] <= lerp_res;
        5'd21: lr_r[4] <= lerp_res;
        5'd22: lr_r[5] <= lerp_res;
        5'd24: lr_r[6] <= lerp_res;
        5'd25: amp_r <= p_r[39:16];
        5'd26: tot_r <= tot_r + 40'($signed(p_r[51:16]));
        default: ;
      endcase
    end
    if (out_ld) begin
      if (tot_r > 40'sd2147483647) begin
        noise_r <= 32'h7FFF_FFFF;
        sat_r   <= 1'b1;
      end else if (tot_r < -40'sd2147483648) begin
        noise_r <= 32'h8000_0000;
        sat_r   <= 1'b1;
      end else begin
        noise_r <= tot_r[31:0];
        sat_r   <= 1'b0;
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OCT) |-> (step_r <= LAST_STEP))
    else $error("octave step out of range");

  a_oct_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OCT) |-> (k_r < n_r))
    else $error("octave index beyond count");

  a_zero_oct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_eval && (n_ev == '0)) |=> (state_r == ST_DONE))
    else $error("empty evaluation did not finish at once");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sat_r) |-> (noise_r == 32'h7FFF_FFFF || noise_r == 32'h8000_0000))
    else $error("saturated item with unclipped value");

endmodule
`default_nettype wire

// ===== src/fractal_perlin_noise_3d_core.sv =====
// Top level of the fractal 3D Perlin noise core
// Load item: written to the permutation table at acceptance.
// Evaluate item: PREP steps and N octave passes precede the registered result (none when N = 0),
// N = octaves run (octave_count clipped to MAX_OCTAVES, zero when persistence is 0 or above one).
// One item at a time (in_tready high only in idle); each octave runs on the shared multiplier,
// with its 14 table reads through the single read port overlapped with the fade.
// Reset: control and config regs to defaults, datapath not reset; table undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module fractal_perlin_noise_3d_core
  import fpn_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // table_index, table_value, coord_x, coord_y, coord_z
  input  wire logic [0:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // noise_value
  output logic [0:0]       out_tuser,  // saturated
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  cfg_regs_t cfg;

  fpn_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  fpn_eng #(.MAX_OCTAVES(MAX_OCTAVES)) u_eng (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_op       (in_tuser[0]),
    .tbl_idx     (in_tdata[7:0]),
    .tbl_val     (in_tdata[15:8]),
    .crd_x       (in_tdata[39:16]),
    .crd_y       (in_tdata[63:40]),
    .crd_z       (in_tdata[87:64]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .noise_value (out_tdata),
    .saturated   (out_tuser[0])
  );

endmodule
`default_nettype wire
